// ===== design/etst_pkg.sv =====
package etst_pkg;

    localparam int TIME_W = 64;
    localparam int CNT_W  = 16;

    // Input opcodes
    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic add_step;
        logic mod_step;
        logic check;
        logic scan_step;
        logic commit_skip;
        logic emit;
    } etst_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic in_tick;
        logic slot_free;
        logic idx_last;
        logic mod_last;
        logic mod_zero;
        logic flow;
        logic out_free;
    } etst_status_t;

endpackage

// ===== design/event_time_skip_table_unit.sv =====
// Add event: slots are searched from index 0 for the first free one, which takes the
// event time now_ns + delay_ns; the event is dropped when the table is full.
// Frame tick: a bit-serial remainder of frame count + 1 by the interval, then a check;
// when the remainder is zero and flow is inactive, a slot scan, drain and commit follow.
// One item is in flight at a time; the next is taken while the result beat waits.
// Reset (rst_n, async, active low) empties all slots, clears the frame count, interval 1.
module event_time_skip_table_unit #(
    parameter int SLOTS = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [etst_pkg::CNT_W-1:0]   cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         opcode,
    input  logic [etst_pkg::TIME_W-1:0]  now_ns,
    input  logic [etst_pkg::TIME_W-1:0]  delay_ns,
    input  logic                         flow_active,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         event_posted,
    output logic [etst_pkg::TIME_W-1:0]  post_time_ns,
    output logic                         add_dropped,
    output logic                         skip_taken,
    output logic [etst_pkg::TIME_W-1:0]  skip_ns,
    output logic [etst_pkg::TIME_W-1:0]  skip_target_ns
);
    import etst_pkg::*;

    etst_cmd_t    cmd;
    etst_status_t status;

    // Interval register takes a write every cycle
    assign cfg_ready = 1'b1;

    etst_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    etst_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_valid      (cfg_valid),
        .cfg_data       (cfg_data),
        .opcode         (opcode),
        .now_ns         (now_ns),
        .delay_ns       (delay_ns),
        .flow_active    (flow_active),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .event_posted   (event_posted),
        .post_time_ns   (post_time_ns),
        .add_dropped    (add_dropped),
        .skip_taken     (skip_taken),
        .skip_ns        (skip_ns),
        .skip_target_ns (skip_target_ns)
    );

endmodule

// ===== design/etst_ctrl.sv =====
module etst_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  etst_pkg::etst_status_t status,
    output etst_pkg::etst_cmd_t    cmd
);
    import etst_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_MOD,
        S_CHECK,
        S_SCAN,
        S_DRAIN,
        S_COMMIT,
        S_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == S_IDLE);

    // Decode commands and next state
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = status.in_tick ? S_MOD : S_ADD;
                end
            end
            S_ADD:
            begin
                cmd.add_step = 1'b1;
                if (status.slot_free || status.idx_last)
                begin
                    state_next = S_EMIT;
                end
            end
            S_MOD:
            begin
                cmd.mod_step = 1'b1;
                if (status.mod_last)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = (status.mod_zero && !status.flow) ? S_SCAN : S_EMIT;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.idx_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                cmd.commit_skip = 1'b1;
                state_next      = S_EMIT;
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== design/etst_dp.sv =====
module etst_dp #(
    parameter int SLOTS = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  etst_pkg::etst_cmd_t          cmd,
    output etst_pkg::etst_status_t       status,
    input  logic                         cfg_valid,
    input  logic [etst_pkg::CNT_W-1:0]   cfg_data,
    input  logic                         opcode,
    input  logic [etst_pkg::TIME_W-1:0]  now_ns,
    input  logic [etst_pkg::TIME_W-1:0]  delay_ns,
    input  logic                         flow_active,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         event_posted,
    output logic [etst_pkg::TIME_W-1:0]  post_time_ns,
    output logic                         add_dropped,
    output logic                         skip_taken,
    output logic [etst_pkg::TIME_W-1:0]  skip_ns,
    output logic [etst_pkg::TIME_W-1:0]  skip_target_ns
);
    import etst_pkg::*;

    localparam int IDX_W = $clog2(SLOTS);
    localparam int BIT_W = $clog2(CNT_W);

    // Slot table and occupancy
    logic [TIME_W-1:0] mem [SLOTS];
    logic [SLOTS-1:0]  occ_reg;

    logic [CNT_W-1:0]  interval_reg;
    logic [CNT_W-1:0]  frame_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  div_sh_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [BIT_W-1:0]  bit_reg;

    logic [TIME_W-1:0] now_reg;
    logic [TIME_W-1:0] sum_reg;
    logic              flow_reg;
    logic [IDX_W-1:0]  idx_reg;

    logic [TIME_W-1:0] rd_data_reg;
    logic [IDX_W-1:0]  rd_idx_reg;
    logic              rd_occ_reg;
    logic              rd_valid_reg;

    logic              found_reg;
    logic [TIME_W-1:0] best_reg;
    logic [IDX_W-1:0]  best_idx_reg;

    logic              res_posted_reg;
    logic [TIME_W-1:0] res_time_reg;
    logic              res_dropped_reg;
    logic              res_skip_reg;
    logic [TIME_W-1:0] res_skip_ns_reg;
    logic [TIME_W-1:0] res_target_reg;

    logic              out_valid_reg;
    logic              out_posted_reg;
    logic [TIME_W-1:0] out_time_reg;
    logic              out_dropped_reg;
    logic              out_skip_reg;
    logic [TIME_W-1:0] out_skip_ns_reg;
    logic [TIME_W-1:0] out_target_reg;

    logic [CNT_W-1:0]  iv;
    logic [CNT_W:0]    rem_trial;
    logic [CNT_W:0]    rem_diff;
    logic              slot_free;
    logic              idx_last;
    logic              better;

    assign iv        = (interval_reg == '0) ? CNT_W'(1) : interval_reg;
    assign rem_trial = {rem_reg, div_sh_reg[CNT_W-1]};
    assign rem_diff  = rem_trial - {1'b0, iv};
    assign slot_free = !occ_reg[idx_reg];
    assign idx_last  = (idx_reg == IDX_W'(SLOTS - 1));
    assign better    = rd_valid_reg && rd_occ_reg && (!found_reg || (rd_data_reg < best_reg));

    always_comb
    begin
        status.in_tick   = (opcode == OP_TICK);
        status.slot_free = slot_free;
        status.idx_last  = idx_last;
        status.mod_last  = (bit_reg == BIT_W'(CNT_W - 1));
        status.mod_zero  = (rem_reg == '0);
        status.flow      = flow_reg;
        status.out_free  = !out_valid_reg || out_ready;
    end

    // Table write and registered read
    always_ff @(posedge clk)
    begin
        if (cmd.add_step && slot_free)
        begin
            mem[idx_reg] <= sum_reg;
        end
        if (cmd.scan_step)
        begin
            rd_data_reg <= mem[idx_reg];
        end
    end

    // Control state: occupancy, counters, config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg      <= '0;
            interval_reg <= CNT_W'(1);
            frame_reg    <= '0;
            found_reg    <= 1'b0;
            rd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                interval_reg <= cfg_data;
            end
            // Mark the written slot (unless its time is zero), or free the slot that was skipped to
            if (cmd.add_step && slot_free)
            begin
                occ_reg[idx_reg] <= (sum_reg != '0);
            end
            else if (cmd.commit_skip && found_reg)
            begin
                occ_reg[best_idx_reg] <= 1'b0;
            end
            if (cmd.check)
            begin
                frame_reg <= (rem_reg == '0) ? '0 : count_reg;
            end
            rd_valid_reg <= cmd.scan_step;
            if (cmd.load)
            begin
                found_reg <= 1'b0;
            end
            else if (better)
            begin
                found_reg <= 1'b1;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload and working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            now_reg         <= now_ns;
            sum_reg         <= now_ns + delay_ns;
            flow_reg        <= flow_active;
            idx_reg         <= '0;
            count_reg       <= frame_reg + CNT_W'(1);
            div_sh_reg      <= frame_reg + CNT_W'(1);
            rem_reg         <= '0;
            bit_reg         <= '0;
            res_posted_reg  <= 1'b0;
            res_time_reg    <= '0;
            res_dropped_reg <= 1'b0;
            res_skip_reg    <= 1'b0;
            res_skip_ns_reg <= '0;
            res_target_reg  <= '0;
        end
        // First-free search, one slot a cycle
        if (cmd.add_step)
        begin
            if (slot_free)
            begin
                res_posted_reg <= 1'b1;
                res_time_reg   <= sum_reg;
            end
            else if (idx_last)
            begin
                res_dropped_reg <= 1'b1;
            end
            else
            begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
        end
        // Restoring remainder, one bit a cycle
        if (cmd.mod_step)
        begin
            rem_reg    <= (rem_trial >= {1'b0, iv}) ? rem_diff[CNT_W-1:0]
                                                   : rem_trial[CNT_W-1:0];
            div_sh_reg <= {div_sh_reg[CNT_W-2:0], 1'b0};
            bit_reg    <= bit_reg + BIT_W'(1);
        end
        // Minimum scan: issue read, compare in the next cycle
        if (cmd.scan_step)
        begin
            rd_idx_reg <= idx_reg;
            rd_occ_reg <= occ_reg[idx_reg];
            if (!idx_last)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
        end
        if (better)
        begin
            best_reg     <= rd_data_reg;
            best_idx_reg <= rd_idx_reg;
        end
        if (cmd.commit_skip && found_reg)
        begin
            res_skip_reg    <= 1'b1;
            res_skip_ns_reg <= best_reg - now_reg;
            res_target_reg  <= best_reg;
        end
        // Load the output beat
        if (cmd.emit)
        begin
            out_posted_reg  <= res_posted_reg;
            out_time_reg    <= res_time_reg;
            out_dropped_reg <= res_dropped_reg;
            out_skip_reg    <= res_skip_reg;
            out_skip_ns_reg <= res_skip_ns_reg;
            out_target_reg  <= res_target_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign event_posted   = out_posted_reg;
    assign post_time_ns   = out_time_reg;
    assign add_dropped    = out_dropped_reg;
    assign skip_taken     = out_skip_reg;
    assign skip_ns        = out_skip_ns_reg;
    assign skip_target_ns = out_target_reg;

endmodule

// ===== design/etst_checker.sv =====
module etst_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic                         event_posted,
    input logic [etst_pkg::TIME_W-1:0]  post_time_ns,
    input logic                         add_dropped,
    input logic                         skip_taken,
    input logic [etst_pkg::TIME_W-1:0]  skip_ns,
    input logic [etst_pkg::TIME_W-1:0]  skip_target_ns
);

    // Stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(event_posted)
            && $stable(post_time_ns) && $stable(skip_taken) && $stable(skip_ns))
        else $error("result beat changed while stalled");

    // An add and a skip never report in the same beat, nor a post and a drop
    a_kind_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(event_posted && add_dropped)
            && !(skip_taken && (event_posted || add_dropped)))
        else $error("add and skip flags mixed in one beat");

    // Skip fields are zero without a skip, and a skip target is never empty
    a_skip_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (skip_taken ? (skip_target_ns != '0)
                                  : (skip_ns == '0 && skip_target_ns == '0)))
        else $error("skip fields inconsistent with skip_taken");

    // Event time is zero unless posted
    a_post_field: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !event_posted |-> post_time_ns == '0)
        else $error("event time set on a beat that posted nothing");

endmodule

bind event_time_skip_table_unit etst_checker u_etst_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .event_posted   (event_posted),
    .post_time_ns   (post_time_ns),
    .add_dropped    (add_dropped),
    .skip_taken     (skip_taken),
    .skip_ns        (skip_ns),
    .skip_target_ns (skip_target_ns)
);
